// ===== rtl/core/dpb_pkg.sv =====
// Shared widths, register indexes and sideband types for depth back-projection.
`timescale 1ns / 1ps
package dpb_pkg;
    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;
    localparam int FOC_W      = 20;
    localparam int UPM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_W      = 32;
    localparam int CU_W       = COORD_BITS + 4;
    localparam int DM_W       = ((CU_W > FOC_W) ? CU_W : FOC_W) + 1;
    localparam int ZQ_W       = 32;
    localparam int ZN_W       = (DEPTH_BITS + 16 > ZQ_W) ? DEPTH_BITS + 16 : ZQ_W + 1;
    localparam int ZH_W       = ZN_W - ZQ_W;
    localparam int PQ_W       = 33;
    localparam int P_W        = DM_W + ZQ_W;
    localparam int PH_W       = P_W - PQ_W;
    localparam int IN_W       = DEPTH_BITS + 2 * COORD_BITS;
    localparam int IN_TD_W    = ((IN_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_UPM      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic            neg_x;
        logic [DM_W-1:0] mag_x;
        logic            neg_y;
        logic [DM_W-1:0] mag_y;
    } t_side;
endpackage

// ===== rtl/core/dpb_zdiv.sv =====
// Pipelined restoring divider producing depth in metres, one quotient bit per stage.
`timescale 1ns / 1ps
module dpb_zdiv
    import dpb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [UPM_W-1:0] i_den,
    input  logic             i_valid,
    input  logic             i_sat,
    input  logic [UPM_W-1:0] i_rem,
    input  logic [ZQ_W-1:0]  i_nq,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [ZQ_W-1:0]  o_z,
    output t_side            o_side
);
    logic             r_v    [0:ZQ_W];
    logic             r_sat  [0:ZQ_W];
    logic [UPM_W-1:0] r_rem  [0:ZQ_W];
    logic [ZQ_W-1:0]  r_nq   [0:ZQ_W];
    t_side            r_side [0:ZQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_sat[0]  <= i_sat;
            r_rem[0]  <= i_rem;
            r_nq[0]   <= i_nq;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < ZQ_W; k++) begin : g_step
        logic [UPM_W:0]   t;
        logic             ge;
        logic [UPM_W:0]   diff;
        logic [UPM_W-1:0] n_rem;
        assign t     = {r_rem[k], r_nq[k][ZQ_W-1]};
        assign ge    = t >= {1'b0, i_den};
        assign diff  = t - {1'b0, i_den};
        assign n_rem = ge ? diff[UPM_W-1:0] : t[UPM_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_sat[k+1]  <= r_sat[k];
                r_rem[k+1]  <= n_rem;
                r_nq[k+1]   <= {r_nq[k][ZQ_W-2:0], ge};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[ZQ_W];
    assign o_z     = r_sat[ZQ_W] ? {ZQ_W{1'b1}} : r_nq[ZQ_W];
    assign o_side  = r_side[ZQ_W];
endmodule

// ===== rtl/core/dpb_proj.sv =====
// Pipelined restoring dividers for both lateral axes, one quotient bit per stage.
`timescale 1ns / 1ps
module dpb_proj
    import dpb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [FOC_W-1:0] i_den_x,
    input  logic [FOC_W-1:0] i_den_y,
    input  logic             i_valid,
    input  logic [P_W-1:0]   i_px,
    input  logic [P_W-1:0]   i_py,
    input  logic             i_neg_x,
    input  logic             i_neg_y,
    input  logic [ZQ_W-1:0]  i_z,
    output logic             o_valid,
    output logic [1:0]       o_sat,
    output logic [1:0]       o_neg,
    output logic [PQ_W-1:0]  o_qx,
    output logic [PQ_W-1:0]  o_qy,
    output logic [ZQ_W-1:0]  o_z
);
    logic             r_v   [0:PQ_W];
    logic [1:0]       r_sat [0:PQ_W];
    logic [1:0]       r_neg [0:PQ_W];
    logic [FOC_W-1:0] r_rx  [0:PQ_W];
    logic [FOC_W-1:0] r_ry  [0:PQ_W];
    logic [PQ_W-1:0]  r_qx  [0:PQ_W];
    logic [PQ_W-1:0]  r_qy  [0:PQ_W];
    logic [ZQ_W-1:0]  r_z   [0:PQ_W];

    logic [PH_W-1:0] hx, hy;
    logic            sx, sy;
    assign hx = i_px[P_W-1:PQ_W];
    assign hy = i_py[P_W-1:PQ_W];
    assign sx = 64'(hx) >= 64'(i_den_x);
    assign sy = 64'(hy) >= 64'(i_den_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_sat[0] <= {sy, sx};
            r_neg[0] <= {i_neg_y, i_neg_x};
            r_rx[0]  <= sx ? '0 : FOC_W'(hx);
            r_ry[0]  <= sy ? '0 : FOC_W'(hy);
            r_qx[0]  <= i_px[PQ_W-1:0];
            r_qy[0]  <= i_py[PQ_W-1:0];
            r_z[0]   <= i_z;
        end
    end

    for (genvar k = 0; k < PQ_W; k++) begin : g_step
        logic [FOC_W:0] tx, ty, dx, dy;
        logic           gx, gy;
        assign tx = {r_rx[k], r_qx[k][PQ_W-1]};
        assign ty = {r_ry[k], r_qy[k][PQ_W-1]};
        assign gx = tx >= {1'b0, i_den_x};
        assign gy = ty >= {1'b0, i_den_y};
        assign dx = tx - {1'b0, i_den_x};
        assign dy = ty - {1'b0, i_den_y};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_sat[k+1] <= r_sat[k];
                r_neg[k+1] <= r_neg[k];
                r_rx[k+1]  <= gx ? dx[FOC_W-1:0] : tx[FOC_W-1:0];
                r_ry[k+1]  <= gy ? dy[FOC_W-1:0] : ty[FOC_W-1:0];
                r_qx[k+1]  <= {r_qx[k][PQ_W-2:0], gx};
                r_qy[k+1]  <= {r_qy[k][PQ_W-2:0], gy};
                r_z[k+1]   <= r_z[k];
            end
        end
    end

    assign o_valid = r_v[PQ_W];
    assign o_sat   = r_sat[PQ_W];
    assign o_neg   = r_neg[PQ_W];
    assign o_qx    = r_qx[PQ_W];
    assign o_qy    = r_qy[PQ_W];
    assign o_z     = r_z[PQ_W];
endmodule

// ===== rtl/core/depth_pixel_backprojection.sv =====
// Top level: depth pixel back-projection through a pinhole camera model.
//
// Slave stream: one depth pixel per beat; tdata carries depth_raw, column and
// row_index, tuser carries depth_valid and mask_bit. Master stream: one point
// per beat (point_x, point_y, point_z, Q16.16 metres). Pixels that are masked,
// not valid or of zero depth give no beat.
// Configuration channel: register index and data; writes are always taken
// and must happen only while the pipeline is empty.
// Each pixel passes through 69 register stages: one input stage, 32 stages of
// depth division (one bit each), one multiply stage, 34 stages of lateral
// division (an entry stage, then one bit each) and the output register.
// Throughput is one pixel per cycle while the receiver does not stall. When the
// receiver stalls with a point waiting, the whole pipeline holds and o_s_tready
// falls; nothing is lost or repeated. Reset empties the pipeline and loads the
// default intrinsics (focal 512.0, centre 320.0 / 240.0, 1000 counts per metre).
`timescale 1ns / 1ps
module depth_pixel_backprojection
    import dpb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_TD_W-1:0]   i_s_tdata,  // depth_raw, column, row_index
    input  logic [1:0]           i_s_tuser,  // depth_valid, mask_bit
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [3*OUT_W-1:0]   o_m_tdata,  // point_x, point_y, point_z
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FOC_W-1:0]     i_cfg_data
);
    logic [FOC_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [UPM_W-1:0] r_upm;
    logic [FOC_W-1:0] den_x, den_y;
    logic [UPM_W-1:0] den_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOC_W'(8192);
            r_focal_y  <= FOC_W'(8192);
            r_center_x <= FOC_W'(5120);
            r_center_y <= FOC_W'(3840);
            r_upm      <= UPM_W'(1000);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_UPM:      r_upm      <= i_cfg_data[UPM_W-1:0];
                default: ;
            endcase
        end
    end

    assign den_x = (r_focal_x == '0) ? FOC_W'(1) : r_focal_x;
    assign den_y = (r_focal_y == '0) ? FOC_W'(1) : r_focal_y;
    assign den_z = (r_upm == '0) ? UPM_W'(1) : r_upm;

    logic r_out_valid;
    logic en;
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // Input decode
    logic [DEPTH_BITS-1:0] raw;
    logic [COORD_BITS-1:0] u, v;
    logic                  keep;
    logic [ZN_W-1:0]       num;
    logic [ZH_W-1:0]       num_hi;
    logic                  z_sat;
    logic [DM_W-1:0]       dx, dy;
    t_side                 side;

    assign raw    = i_s_tdata[DEPTH_BITS-1:0];
    assign u      = i_s_tdata[DEPTH_BITS +: COORD_BITS];
    assign v      = i_s_tdata[DEPTH_BITS+COORD_BITS +: COORD_BITS];
    assign keep   = i_s_tvalid && i_s_tuser[0] && i_s_tuser[1] && (raw != '0);
    assign num    = ZN_W'(raw) << 16;
    assign num_hi = num[ZN_W-1:ZQ_W];
    assign z_sat  = 64'(num_hi) >= 64'(den_z);
    assign dx     = DM_W'({u, 4'b0000}) - DM_W'(r_center_x);
    assign dy     = DM_W'({v, 4'b0000}) - DM_W'(r_center_y);
    assign side.neg_x = dx[DM_W-1];
    assign side.mag_x = dx[DM_W-1] ? (~dx + DM_W'(1)) : dx;
    assign side.neg_y = dy[DM_W-1];
    assign side.mag_y = dy[DM_W-1] ? (~dy + DM_W'(1)) : dy;

    logic            zv;
    logic [ZQ_W-1:0] z;
    t_side           zside;

    dpb_zdiv u_zdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_den   (den_z),
        .i_valid (keep),
        .i_sat   (z_sat),
        .i_rem   (z_sat ? '0 : UPM_W'(num_hi)),
        .i_nq    (num[ZQ_W-1:0]),
        .i_side  (side),
        .o_valid (zv),
        .o_z     (z),
        .o_side  (zside)
    );

    // Multiply stage
    logic            r_m_valid;
    logic [P_W-1:0]  r_px, r_py;
    logic            r_neg_x, r_neg_y;
    logic [ZQ_W-1:0] r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= zv;
        end
        if (en) begin
            r_px    <= P_W'(zside.mag_x) * P_W'(z);
            r_py    <= P_W'(zside.mag_y) * P_W'(z);
            r_neg_x <= zside.neg_x;
            r_neg_y <= zside.neg_y;
            r_z     <= z;
        end
    end

    logic            pv;
    logic [1:0]      psat, pneg;
    logic [PQ_W-1:0] qx, qy;
    logic [ZQ_W-1:0] pz;

    dpb_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_den_x (den_x),
        .i_den_y (den_y),
        .i_valid (r_m_valid),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_neg_x (r_neg_x),
        .i_neg_y (r_neg_y),
        .i_z     (r_z),
        .o_valid (pv),
        .o_sat   (psat),
        .o_neg   (pneg),
        .o_qx    (qx),
        .o_qy    (qy),
        .o_z     (pz)
    );

    function automatic logic [OUT_W-1:0] clamp_q(input logic neg, input logic sat,
                                                 input logic [PQ_W-1:0] q);
        logic [PQ_W-1:0] nq;
        nq = ~q + PQ_W'(1);
        if (neg) begin
            clamp_q = (sat || q > PQ_W'(33'h080000000)) ? 32'h80000000 : nq[OUT_W-1:0];
        end else begin
            clamp_q = (sat || q > PQ_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : q[OUT_W-1:0];
        end
    endfunction

    logic [OUT_W-1:0] r_x, r_y, r_zo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= pv;
        end
        if (en) begin
            r_x  <= clamp_q(pneg[0], psat[0], qx);
            r_y  <= clamp_q(pneg[1], psat[1], qy);
            r_zo <= pz;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_zo, r_y, r_x};
endmodule
